@@ hw/rtl/srst_pkg.sv @@
// ----------------------------------------------------------------------------
// srst_pkg
// Operation and status codes shared by the range set table and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package srst_pkg;

    // operation codes carried in func
    typedef enum logic [1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_REMOVE   = 2'd1,
        FUNC_CONTAINS = 2'd2,
        FUNC_CLEAR    = 2'd3
    } t_func;

    // status codes of a result
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_READONLY = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

endpackage

`default_nettype wire

@@ hw/rtl/srst_if.sv @@
// ----------------------------------------------------------------------------
// srst_if
// Valid/ready channels of the range set table: command, response, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface srst_cmd_if #(
    parameter int VALUE_BITS = 22
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [VALUE_BITS-1:0] low_value;
    logic signed [VALUE_BITS-1:0] high_value;

    modport source (output valid, func, low_value, high_value, input ready);
    modport sink   (input valid, func, low_value, high_value, output ready);
endinterface

interface srst_rsp_if #(
    parameter int CNT_BITS = 7
);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic                member;
    logic [CNT_BITS-1:0] range_count;

    modport source (output valid, status, member, range_count, input ready);
    modport sink   (input valid, status, member, range_count, output ready);
endinterface

interface srst_cfg_if;
    logic valid;
    logic ready;
    logic read_only;

    modport source (output valid, read_only, input ready);
    modport sink   (input valid, read_only, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sorted_range_set_table.sv @@
// ----------------------------------------------------------------------------
// sorted_range_set_table
// Sorted table of disjoint, non-adjacent signed ranges held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one operation per transfer (add range, remove element,
//   contains, clear); o_rsp returns exactly one result per command with the
//   status, the membership answer and the range count after the operation.
//   i_cfg writes the read_only bit; it is always ready; the user must write
//   it only while the block is idle, the block itself does not enforce this.
// Timing:
//   one command at a time. The table is scanned from entry 0, each entry
//   read from memory, then compared; a merge continues that scan, and
//   each entry shifted on insert or delete is read, then written, one
//   access at a time through the table memory.
// Reset:
//   the range count and read_only clear at once; the memory is not cleared,
//   entries at or above the count are never read.
// Back-pressure:
//   a result waits in the output register while o_rsp.ready is low; the
//   next command is taken meanwhile and its result waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_range_set_table #(
    parameter int MAX_RANGES = 64,
    parameter int VALUE_BITS = 22
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    srst_cmd_if.sink       i_cmd,
    srst_rsp_if.source     o_rsp,
    srst_cfg_if.sink       i_cfg
);

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int VB = VALUE_BITS;
    localparam int EW = VALUE_BITS + 2;
    localparam logic [CW-1:0]        MAX_C = CW'(MAX_RANGES);
    localparam logic [CW-1:0]        C_ONE = CW'(1);
    localparam logic signed [EW-1:0] X_ONE = EW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_MRG_RD, S_MRG_CMP,
        S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_WR_I, S_WR_J, S_OUT
    } t_state;

    t_state                r_state;
    logic [1:0]            r_func;
    logic signed [VB-1:0]  r_lo, r_hi, r_nlo, r_nhi, r_a, r_b;
    logic [CW-1:0]         r_used, r_idx, r_i, r_src, r_dst;
    logic                  r_split, r_close, r_member, r_ro;
    logic [1:0]            r_status;
    logic                  r_ov, r_om;
    logic [1:0]            r_ost;
    logic [CW-1:0]         r_ocnt;

    // table memory: {start, end}
    logic [2*VB-1:0] mem [MAX_RANGES];
    logic [2*VB-1:0] r_rdata;
    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic [2*VB-1:0] wr_data;
    logic [CW-1:0]   src_m1, i_p1;

    logic signed [VB-1:0] rd_s, rd_e;
    logic signed [EW-1:0] x_lo, x_hi, x_s, x_e, lo_m1, lo_p1, hi_p1;

    assign rd_s  = r_rdata[2*VB-1:VB];
    assign rd_e  = r_rdata[VB-1:0];
    assign x_lo  = EW'(r_lo);
    assign x_hi  = EW'(r_hi);
    assign x_s   = EW'(rd_s);
    assign x_e   = EW'(rd_e);
    assign lo_m1 = x_lo - X_ONE;
    assign lo_p1 = x_lo + X_ONE;
    assign hi_p1 = x_hi + X_ONE;
    assign src_m1 = r_src - C_ONE;
    assign i_p1   = r_i + C_ONE;

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_i[AW-1:0];
        wr_data = {r_nlo, r_nhi};
        unique case (r_state)
            S_SCAN_RD, S_MRG_RD: begin
                rd_en   = (r_idx != r_used);
                rd_addr = r_idx[AW-1:0];
            end
            S_DN_RD: begin
                rd_en   = (r_src != r_used);
                rd_addr = r_src[AW-1:0];
            end
            S_UP_RD: begin
                rd_en   = (r_src != r_dst);
                rd_addr = src_m1[AW-1:0];
            end
            S_DN_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_dst[AW-1:0];
                wr_data = r_rdata;
            end
            S_UP_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_src[AW-1:0];
                wr_data = r_rdata;
            end
            S_WR_I: begin
                wr_en   = 1'b1;
                wr_addr = r_i[AW-1:0];
                wr_data = {r_nlo, r_nhi};
            end
            S_WR_J: begin
                wr_en   = 1'b1;
                wr_addr = i_p1[AW-1:0];
                wr_data = {r_a, r_b};
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ro <= 1'b0;
        end else if (i_cfg.valid) begin
            r_ro <= i_cfg.read_only;
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_ost;
    assign o_rsp.member      = r_om;
    assign o_rsp.range_count = r_ocnt;

    // operation sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // result slot empties on transfer unless refilled in S_OUT
            if (r_ov && o_rsp.ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_func   <= i_cmd.func;
                        r_lo     <= i_cmd.low_value;
                        r_hi     <= i_cmd.high_value;
                        r_idx    <= '0;
                        r_split  <= 1'b0;
                        r_close  <= 1'b0;
                        r_member <= 1'b0;
                        r_status <= srst_pkg::ST_DONE;
                        if (i_cmd.func == srst_pkg::FUNC_CONTAINS) begin
                            r_state <= S_SCAN_RD;
                        end else if (r_ro) begin
                            r_status <= srst_pkg::ST_READONLY;
                            r_state  <= S_OUT;
                        end else if (i_cmd.func == srst_pkg::FUNC_CLEAR) begin
                            r_used  <= '0;
                            r_state <= S_OUT;
                        end else if (i_cmd.func == srst_pkg::FUNC_ADD &&
                                     i_cmd.high_value < i_cmd.low_value) begin
                            r_status <= srst_pkg::ST_EMPTY;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    if (r_idx == r_used) begin
                        if (r_func == srst_pkg::FUNC_ADD) begin
                            if (r_used == MAX_C) begin
                                r_status <= srst_pkg::ST_FULL;
                                r_state  <= S_OUT;
                            end else begin
                                r_i     <= r_idx;
                                r_nlo   <= r_lo;
                                r_nhi   <= r_hi;
                                r_src   <= r_used;
                                r_dst   <= r_idx;
                                r_state <= S_UP_RD;
                            end
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_SCAN_CMP;
                    end
                end
                S_SCAN_CMP: begin
                    if ((r_func == srst_pkg::FUNC_ADD) ? (x_e < lo_m1) : (x_e < x_lo)) begin
                        r_idx   <= r_idx + C_ONE;
                        r_state <= S_SCAN_RD;
                    end else if (r_func == srst_pkg::FUNC_CONTAINS) begin
                        r_member <= (x_s <= x_lo);
                        r_state  <= S_OUT;
                    end else if (r_func == srst_pkg::FUNC_ADD) begin
                        if (x_s <= hi_p1) begin
                            // overlaps or touches: start merging
                            r_i     <= r_idx;
                            r_nlo   <= (x_s < x_lo) ? rd_s : r_lo;
                            r_nhi   <= (x_e > x_hi) ? rd_e : r_hi;
                            r_idx   <= r_idx + C_ONE;
                            r_state <= S_MRG_RD;
                        end else if (r_used == MAX_C) begin
                            r_status <= srst_pkg::ST_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_i     <= r_idx;
                            r_nlo   <= r_lo;
                            r_nhi   <= r_hi;
                            r_src   <= r_used;
                            r_dst   <= r_idx;
                            r_state <= S_UP_RD;
                        end
                    end else begin
                        // remove element
                        r_i <= r_idx;
                        if (x_s > x_lo) begin
                            r_state <= S_OUT;
                        end else if (x_s == x_lo && x_e == x_lo) begin
                            r_dst   <= r_idx;
                            r_src   <= r_idx + C_ONE;
                            r_state <= S_DN_RD;
                        end else if (x_s == x_lo) begin
                            r_nlo   <= VB'(lo_p1);
                            r_nhi   <= rd_e;
                            r_state <= S_WR_I;
                        end else if (x_e == x_lo) begin
                            r_nlo   <= rd_s;
                            r_nhi   <= VB'(lo_m1);
                            r_state <= S_WR_I;
                        end else if (r_used == MAX_C) begin
                            r_status <= srst_pkg::ST_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            // split in two
                            r_nlo   <= rd_s;
                            r_nhi   <= VB'(lo_m1);
                            r_a     <= VB'(lo_p1);
                            r_b     <= rd_e;
                            r_split <= 1'b1;
                            r_src   <= r_used;
                            r_dst   <= r_idx + C_ONE;
                            r_state <= S_UP_RD;
                        end
                    end
                end
                S_MRG_RD: begin
                    if (r_idx == r_used) begin
                        r_close <= 1'b1;
                        r_dst   <= i_p1;
                        r_src   <= r_idx;
                        r_state <= S_WR_I;
                    end else begin
                        r_state <= S_MRG_CMP;
                    end
                end
                S_MRG_CMP: begin
                    if (x_s <= hi_p1) begin
                        if (x_e > EW'(r_nhi)) begin
                            r_nhi <= rd_e;
                        end
                        r_idx   <= r_idx + C_ONE;
                        r_state <= S_MRG_RD;
                    end else begin
                        r_close <= 1'b1;
                        r_dst   <= i_p1;
                        r_src   <= r_idx;
                        r_state <= S_WR_I;
                    end
                end
                S_UP_RD: begin
                    if (r_src == r_dst) begin
                        r_used  <= r_used + C_ONE;
                        r_state <= S_WR_I;
                    end else begin
                        r_state <= S_UP_WR;
                    end
                end
                S_UP_WR: begin
                    r_src   <= src_m1;
                    r_state <= S_UP_RD;
                end
                S_DN_RD: begin
                    if (r_src == r_used) begin
                        r_used  <= r_used - (r_src - r_dst);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DN_WR;
                    end
                end
                S_DN_WR: begin
                    r_src   <= r_src + C_ONE;
                    r_dst   <= r_dst + C_ONE;
                    r_state <= S_DN_RD;
                end
                S_WR_I: begin
                    if (r_split) begin
                        r_state <= S_WR_J;
                    end else if (r_close) begin
                        r_state <= S_DN_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_WR_J: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov    <= 1'b1;
                        r_ost   <= r_status;
                        r_om    <= r_member;
                        r_ocnt  <= r_used;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/srst_chk.sv @@
// ----------------------------------------------------------------------------
// srst_chk
// Port-level checks of the range set table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srst_chk #(
    parameter int MAX_RANGES = 64,
    parameter int CW         = 7
) (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_valid,
    input wire            i_ready,
    input wire [1:0]      i_status,
    input wire            i_member,
    input wire [CW-1:0]   i_count
);

    // a stalled result stays presented
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_count))
        else $error("result dropped or changed while stalled");

    // the count never exceeds the table depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_count <= CW'(MAX_RANGES))
        else $error("range count beyond table depth");

    // a membership hit only comes with a done status
    a_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_member |-> i_status == srst_pkg::ST_DONE)
        else $error("member flag with failure status");

    // a full table answer only when the table is full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == srst_pkg::ST_FULL |-> i_count == CW'(MAX_RANGES))
        else $error("full status with room left");

endmodule

bind sorted_range_set_table srst_chk #(
    .MAX_RANGES (MAX_RANGES),
    .CW         ($clog2(MAX_RANGES + 1))
) u_srst_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_status (o_rsp.status),
    .i_member (o_rsp.member),
    .i_count  (o_rsp.range_count)
);

`default_nettype wire

@@ bench/srst_checker.sv @@
// ----------------------------------------------------------------------------
// srst_checker
// Watches the command, response and config channels of the range set table,
// keeps its own copy of the table, and checks every response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srst_checker #(
    parameter int MAX_RANGES = 64,
    parameter int VALUE_BITS = 22
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    srst_cmd_if.sink   i_cmd,
    srst_rsp_if.sink   i_rsp,
    srst_cfg_if.sink   i_cfg,
    output int         o_errors,
    output int         o_pending
);

    typedef struct packed {
        logic [1:0] status;
        logic       member;
        logic [6:0] count;
    } t_answer;

    typedef logic signed [VALUE_BITS:0] t_val;

    t_val    tbl_lo [MAX_RANGES+1];
    t_val    tbl_hi [MAX_RANGES+1];
    int      used;
    logic    ro;
    t_answer answers_due [$];

    assign o_pending = answers_due.size();

    // shift entries pos.. up by one
    task automatic open_gap(input int pos);
        for (int k = used; k > pos; k--) begin
            tbl_lo[k] = tbl_lo[k-1];
            tbl_hi[k] = tbl_hi[k-1];
        end
        used++;
    endtask

    // drop cnt entries at pos
    task automatic close_gap(input int pos, input int cnt);
        for (int k = pos; k + cnt < used; k++) begin
            tbl_lo[k] = tbl_lo[k+cnt];
            tbl_hi[k] = tbl_hi[k+cnt];
        end
        used -= cnt;
    endtask

    task automatic add_range(input t_val lo, input t_val hi, output srst_pkg::t_status st);
        int i;
        int j;
        i = 0;
        st = srst_pkg::ST_DONE;
        if (hi < lo) begin
            st = srst_pkg::ST_EMPTY;
            return;
        end
        while (i < used && tbl_hi[i] < lo - 1) i++;
        if (i < used && tbl_lo[i] <= hi + 1) begin
            j = i;
            while (j + 1 < used && tbl_lo[j+1] <= hi + 1) j++;
            if (tbl_lo[i] < lo) lo = tbl_lo[i];
            if (tbl_hi[j] > hi) hi = tbl_hi[j];
            tbl_lo[i] = lo;
            tbl_hi[i] = hi;
            close_gap(i + 1, j - i);
        end else if (used >= MAX_RANGES) begin
            st = srst_pkg::ST_FULL;
        end else begin
            open_gap(i);
            tbl_lo[i] = lo;
            tbl_hi[i] = hi;
        end
    endtask

    task automatic remove_value(input t_val el, output srst_pkg::t_status st);
        st = srst_pkg::ST_DONE;
        for (int i = 0; i < used; i++) begin
            if (el < tbl_lo[i]) break;
            if (el > tbl_hi[i]) continue;
            if (el == tbl_lo[i] && el == tbl_hi[i]) begin
                close_gap(i, 1);
            end else if (el == tbl_lo[i]) begin
                tbl_lo[i] = t_val'(el + 1);
            end else if (el == tbl_hi[i]) begin
                tbl_hi[i] = t_val'(el - 1);
            end else if (used >= MAX_RANGES) begin
                st = srst_pkg::ST_FULL;
            end else begin
                open_gap(i + 1);
                tbl_hi[i+1] = tbl_hi[i];
                tbl_hi[i]   = t_val'(el - 1);
                tbl_lo[i+1] = t_val'(el + 1);
            end
            break;
        end
    endtask

    function automatic logic holds(input t_val el);
        for (int i = 0; i < used; i++) begin
            if (el < tbl_lo[i]) return 1'b0;
            if (el <= tbl_hi[i]) return 1'b1;
        end
        return 1'b0;
    endfunction

    // predict on each command transfer, compare on each response transfer
    always @(posedge i_clk) begin
        t_answer a;
        t_answer got;
        srst_pkg::t_status st;
        if (!i_rst_n) begin
            used = 0;
            ro = 1'b0;
            o_errors <= 0;
            answers_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) ro = i_cfg.read_only;
            if (i_cmd.valid && i_cmd.ready) begin
                st = srst_pkg::ST_DONE;
                a.member = 1'b0;
                if (i_cmd.func == srst_pkg::FUNC_CONTAINS) begin
                    a.member = holds(t_val'(i_cmd.low_value));
                end else if (ro) begin
                    st = srst_pkg::ST_READONLY;
                end else if (i_cmd.func == srst_pkg::FUNC_ADD) begin
                    add_range(t_val'(i_cmd.low_value), t_val'(i_cmd.high_value), st);
                end else if (i_cmd.func == srst_pkg::FUNC_REMOVE) begin
                    remove_value(t_val'(i_cmd.low_value), st);
                end else begin
                    used = 0;
                end
                a.status = st;
                a.count = 7'(used);
                answers_due.insert(answers_due.size(), a);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.status, i_rsp.member, i_rsp.range_count};
                if (answers_due.size() == 0) begin
                    $error("response with no command outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    a = answers_due.pop_front();
                    if (got.status != a.status || got.member != a.member ||
                        got.count != a.count) o_errors <= o_errors + 1;
                    if (got.status != a.status)
                        $error("status expected %0d actual %0d", a.status, got.status);
                    if (got.member != a.member)
                        $error("member expected %0d actual %0d", a.member, got.member);
                    if (got.count != a.count)
                        $error("range_count expected %0d actual %0d", a.count, got.count);
                end
            end
        end
    end

endmodule

@@ bench/sorted_range_set_table_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_range_set_table_tb
// Drives directed and random range commands with random idling and long
// response stalls through several read_only settings; a checker module
// predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_range_set_table_tb;

    localparam int MAX_RANGES = 64;
    localparam int VALUE_BITS = 22;
    localparam int LIMIT      = 1000000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   calm;
    bit   hold_rsp;

    srst_cmd_if #(.VALUE_BITS(VALUE_BITS)) cmd ();
    srst_rsp_if #(.CNT_BITS(7))            rsp ();
    srst_cfg_if                            cfg ();

    sorted_range_set_table #(.MAX_RANGES(MAX_RANGES), .VALUE_BITS(VALUE_BITS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_rsp(rsp), .i_cfg(cfg)
    );

    srst_checker #(.MAX_RANGES(MAX_RANGES), .VALUE_BITS(VALUE_BITS)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_rsp(rsp), .i_cfg(cfg),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, or a long hold when asked
    initial begin
        int n;
        rsp.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_rsp) begin
                rsp.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_rsp = 1'b0;
            end else if (!calm && $urandom_range(3) == 0) begin
                n = $urandom_range(1, 13);
                rsp.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                rsp.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // valid stays up after a transfer until the next command or an idle gap
    task automatic send(input srst_pkg::t_func f, input int lo, input int hi);
        if (!calm && $urandom_range(3) == 0) begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        cmd.valid      <= 1'b1;
        cmd.func       <= f;
        cmd.low_value  <= VALUE_BITS'(lo);
        cmd.high_value <= VALUE_BITS'(hi);
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_ro(input logic v);
        drain();
        cfg.valid     <= 1'b1;
        cfg.read_only <= v;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // random value: mostly a narrow window so ranges collide, sometimes anything
    function automatic int pick(input int base);
        case ($urandom_range(9))
            0: return $urandom_range(1114112) - 1;
            1: return $signed(VALUE_BITS'($urandom));
            default: return base + $urandom_range(200);
        endcase
    endfunction

    task automatic random_phase(input int count, input int base);
        int lo;
        int f;
        for (int k = 0; k < count; k++) begin
            lo = pick(base);
            f = $urandom_range(19);
            if (f < 9) send(srst_pkg::FUNC_ADD, lo, lo + $urandom_range(6) - 1);
            else if (f < 14) send(srst_pkg::FUNC_REMOVE, lo, pick(base));
            else if (f < 19) send(srst_pkg::FUNC_CONTAINS, lo, pick(base));
            else send(srst_pkg::FUNC_CLEAR, lo, pick(base));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        calm           = 1'b0;
        hold_rsp       = 1'b0;
        cmd.valid      = 1'b0;
        cmd.func       = srst_pkg::FUNC_ADD;
        cmd.low_value  = '0;
        cmd.high_value = '0;
        cfg.valid      = 1'b0;
        cfg.read_only  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, merges, splits, empty add, read-only
        send(srst_pkg::FUNC_ADD, -1, 1114111);
        send(srst_pkg::FUNC_CONTAINS, -1, 0);
        send(srst_pkg::FUNC_REMOVE, 5, 0);
        send(srst_pkg::FUNC_REMOVE, -1, 0);
        send(srst_pkg::FUNC_REMOVE, 1114111, 0);
        send(srst_pkg::FUNC_CONTAINS, 5, 0);
        send(srst_pkg::FUNC_CLEAR, 0, 0);
        send(srst_pkg::FUNC_ADD, 10, 9);
        send(srst_pkg::FUNC_ADD, 10, 20);
        send(srst_pkg::FUNC_ADD, 30, 40);
        send(srst_pkg::FUNC_ADD, 21, 29);
        send(srst_pkg::FUNC_ADD, 12, 15);
        send(srst_pkg::FUNC_REMOVE, 100, 0);
        send(srst_pkg::FUNC_ADD, -2097152, 2097151);
        send(srst_pkg::FUNC_CONTAINS, 2097151, -2097152);
        send(srst_pkg::FUNC_CLEAR, 0, 0);
        send(srst_pkg::FUNC_ADD, 7, 7);
        send(srst_pkg::FUNC_REMOVE, 7, 0);
        write_ro(1'b1);
        send(srst_pkg::FUNC_ADD, 1, 2);
        send(srst_pkg::FUNC_REMOVE, 1, 0);
        send(srst_pkg::FUNC_CLEAR, 0, 0);
        send(srst_pkg::FUNC_CONTAINS, 1, 0);
        write_ro(1'b0);

        // fill the table with isolated two-value ranges, then hit full on add and split
        for (int k = 0; k < MAX_RANGES; k++) send(srst_pkg::FUNC_ADD, 4 * k, 4 * k + 1);
        send(srst_pkg::FUNC_ADD, 1000, 1000);
        send(srst_pkg::FUNC_ADD, 2, 2);
        send(srst_pkg::FUNC_REMOVE, 0, 0);
        send(srst_pkg::FUNC_ADD, 0, 0);
        send(srst_pkg::FUNC_ADD, 8, 9);
        send(srst_pkg::FUNC_ADD, 8, 12);
        send(srst_pkg::FUNC_ADD, 1000, 1001);
        send(srst_pkg::FUNC_REMOVE, 9, 0);
        drain();

        // long receiver hold while commands keep coming
        hold_rsp = 1'b1;
        random_phase(40, 0);
        random_phase(60, 0);
        write_ro(1'b1);
        random_phase(30, 0);
        write_ro(1'b0);
        send(srst_pkg::FUNC_CLEAR, 0, 0);
        random_phase(80, -100);
        calm = 1'b1;
        random_phase(70, 500);

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sorted_range_set_table.f @@
hw/rtl/srst_pkg.sv
hw/rtl/srst_if.sv
hw/rtl/sorted_range_set_table.sv
hw/rtl/srst_chk.sv
bench/srst_checker.sv
bench/sorted_range_set_table_tb.sv
